// ===== sv/bsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types, line codes and the CRC-16 byte update for the stuffing framer.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // one frame byte as classified by the front end
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        open;
    logic [15:0] crc;
  } job_t;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_DATA,
    PH_CRCL,
    PH_CRCH,
    PH_CLOSE
  } phase_t;

  // crc-16, poly 0x1021, msb first, one byte per call
  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]} ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

endpackage

// ===== sv/bsf_in_if.sv =====
// ----------------------------------------------------------------------------
// bsf_in_if
// Frame byte channel: valid/ready handshake with data byte and last flag.
// ----------------------------------------------------------------------------
interface bsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/bsf_out_if.sv =====
// ----------------------------------------------------------------------------
// bsf_out_if
// Line byte channel: valid/ready handshake with line byte and marks.
// ----------------------------------------------------------------------------
interface bsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

// ===== sv/byte_stuffing_framer_crc16.sv =====
// ----------------------------------------------------------------------------
// byte_stuffing_framer_crc16
// Byte-stuffed framer with CRC-16 (0x1021, init 0) over each frame.
// ----------------------------------------------------------------------------
//  channel    dir  payload                           transfer
//  byte_in    in   data_byte[7:0], last_byte         valid && ready
//  line_out   out  out_byte[7:0], run_last, frame_end valid && ready
//
//  one line byte leaves per cycle from the encoder's output register while
//  line_out is ready; an item causes 1 to 8 line bytes, 2 for an escaped
//  byte; the front end takes a byte a cycle while the queue has room.
//  rst is synchronous: no frame open, crc zero, queue and output empty.
//  a stall on line_out fills the job queue, then drops byte_in.ready.
// ----------------------------------------------------------------------------
module byte_stuffing_framer_crc16
  import bsf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  bsf_in_if.sink    byte_in,
  bsf_out_if.source line_out
);

  job_t push_job;
  job_t pop_job;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  bsf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .job     (push_job),
    .push    (push),
    .full    (full)
  );

  bsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (not_empty)
  );

  bsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (pop_job),
    .q_valid  (not_empty),
    .pop      (pop),
    .line_out (line_out)
  );

endmodule

// ===== sv/bsf_front.sv =====
// ----------------------------------------------------------------------------
// bsf_front
// Accepts frame bytes, tracks frame state and the running CRC, builds jobs.
// ----------------------------------------------------------------------------
module bsf_front
  import bsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bsf_in_if.sink      byte_in,
  output job_t        job,
  output logic        push,
  input  logic        full
);

  logic        in_frame;
  logic [15:0] crc;
  logic [15:0] crc_base;
  logic [15:0] crc_new;

  assign byte_in.ready = !full;
  assign push          = byte_in.valid && !full;

  // a new frame restarts the crc from zero
  assign crc_base = in_frame ? crc : 16'h0000;
  assign crc_new  = crc16_update(crc_base, byte_in.data_byte);

  assign job.data = byte_in.data_byte;
  assign job.last = byte_in.last_byte;
  assign job.open = !in_frame;
  assign job.crc  = crc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      crc      <= 16'h0000;
    end else if (push) begin
      if (byte_in.last_byte) begin
        in_frame <= 1'b0;
        crc      <= 16'h0000;
      end else begin
        in_frame <= 1'b1;
        crc      <= crc_new;
      end
    end
  end

`ifndef SYNTHESIS
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    push && job.last |=> !in_frame && crc == 16'h0000)
    else $error("frame state not cleared after last byte");
  a_open_mid: assert property (@(posedge clk) disable iff (rst)
    push && !job.last |=> in_frame && crc == $past(crc_new))
    else $error("crc not carried into open frame");
  a_open_mark: assert property (@(posedge clk) disable iff (rst)
    push && in_frame |-> !job.open)
    else $error("open flag requested inside a frame");
`endif

endmodule

// ===== sv/bsf_queue.sv =====
// ----------------------------------------------------------------------------
// bsf_queue
// Small show-ahead FIFO of jobs between the front end and the line encoder.
// ----------------------------------------------------------------------------
module bsf_queue
  import bsf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == DEPTH_C);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue count out of range");
`endif

endmodule

// ===== sv/bsf_back.sv =====
// ----------------------------------------------------------------------------
// bsf_back
// Line encoder: walks each job through flag, data, crc and escape bytes.
// ----------------------------------------------------------------------------
module bsf_back
  import bsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  job_t     q_job,
  input  logic     q_valid,
  output logic     pop,
  bsf_out_if.source line_out
);

  phase_t     phase;
  phase_t     phase_next;
  phase_t     phase_after;
  logic       busy;
  logic       busy_next;
  logic       esc2;
  logic       esc2_next;
  job_t       job;
  logic       can_emit;
  logic       emit;
  logic       special;
  logic       step_done;
  logic       final_byte;
  logic [7:0] cur_val;
  logic [7:0] emit_byte;

  logic       out_valid;
  logic [7:0] out_data;
  logic       out_run_last;
  logic       out_frame_end;

  assign can_emit = !out_valid || line_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPEN;
      busy  <= 1'b0;
      esc2  <= 1'b0;
    end else begin
      phase <= phase_next;
      busy  <= busy_next;
      esc2  <= esc2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
  end

  always_comb begin
    case (phase)
      PH_OPEN:  cur_val = FLAG_BYTE;
      PH_DATA:  cur_val = job.data;
      PH_CRCL:  cur_val = job.crc[7:0];
      PH_CRCH:  cur_val = job.crc[15:8];
      PH_CLOSE: cur_val = FLAG_BYTE;
      default:  cur_val = FLAG_BYTE;
    endcase

    case (phase)
      PH_OPEN:  phase_after = PH_DATA;
      PH_DATA:  phase_after = PH_CRCL;
      PH_CRCL:  phase_after = PH_CRCH;
      PH_CRCH:  phase_after = PH_CLOSE;
      default:  phase_after = PH_CLOSE;
    endcase

    special = (phase == PH_DATA || phase == PH_CRCL || phase == PH_CRCH) &&
              (cur_val == FLAG_BYTE || cur_val == ESC_BYTE);

    if (special && !esc2) begin
      emit_byte = ESC_BYTE;
    end else if (special) begin
      emit_byte = cur_val ^ ESC_XOR;
    end else begin
      emit_byte = cur_val;
    end

    step_done  = !special || esc2;
    final_byte = step_done && ((phase == PH_DATA && !job.last) || phase == PH_CLOSE);

    phase_next = phase;
    busy_next  = busy;
    esc2_next  = esc2;
    emit       = 1'b0;
    pop        = 1'b0;

    if (busy && can_emit) begin
      emit = 1'b1;
      if (!step_done) begin
        esc2_next = 1'b1;
      end else begin
        esc2_next = 1'b0;
        if (final_byte) begin
          busy_next = 1'b0;
        end else begin
          phase_next = phase_after;
        end
      end
    end

    // next job loads on the same edge the current one finishes
    if ((!busy || (emit && final_byte)) && q_valid) begin
      pop        = 1'b1;
      busy_next  = 1'b1;
      esc2_next  = 1'b0;
      phase_next = q_job.open ? PH_OPEN : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (line_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data      <= emit_byte;
      out_run_last  <= final_byte;
      out_frame_end <= (phase == PH_CLOSE);
    end
  end

  assign line_out.valid     = out_valid;
  assign line_out.out_byte  = out_data;
  assign line_out.run_last  = out_run_last;
  assign line_out.frame_end = out_frame_end;

`ifndef SYNTHESIS
  a_end_is_flag: assert property (@(posedge clk) disable iff (rst)
    line_out.valid && line_out.frame_end |->
      line_out.out_byte == FLAG_BYTE && line_out.run_last)
    else $error("frame end not on a closing flag");
  a_esc_pending: assert property (@(posedge clk) disable iff (rst)
    busy && esc2 |-> cur_val == FLAG_BYTE || cur_val == ESC_BYTE)
    else $error("escape pending on a plain byte");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_out.ready |=> out_valid && $stable(out_data))
    else $error("line byte changed while stalled");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> !busy || final_byte)
    else $error("job loaded over unfinished job");
`endif

endmodule

// ===== tb/sv/byte_stuffing_framer_crc16_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffing_framer_crc16_tb
// Self-checking bench for the byte-stuffed CRC-16 framer. A short table of
// hand-picked frame bytes runs first, then random frames whose closing byte is
// often chosen so the CRC itself needs stuffing. Every line byte is compared
// against table bytes or an in-bench frame encoder; both channels idle at
// random and the line side holds off for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module byte_stuffing_framer_crc16_tb;
  import bsf_pkg::*;

  localparam int NUM_ROWS     = 21;
  localparam int RANDOM_BYTES = 140;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] octet;
    logic       run_last;
    logic       frame_end;
  } line_t;

  // nexp = 0: expected bytes come from the frame encoder below
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [3:0]  nexp;
    logic [63:0] exp;
  } row_t;

  logic clk;
  logic rst;

  bsf_in_if  byte_in ();
  bsf_out_if line_out ();

  byte_stuffing_framer_crc16 uut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .line_out (line_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder state
  logic [15:0] line_crc;
  logic        frame_open;
  bit          keep_pred;
  line_t       line_expect [$];

  bit tx_burst;
  bit rx_burst;
  bit hold_req;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned frames_sent;
  int unsigned bytes_sent;
  int unsigned escapes_seen;
  int unsigned holds_done;

  row_t dir_rows [NUM_ROWS] = '{
    '{8'h00, 1'b1, 4'd5, 64'h7e00_0000_7e00_0000},
    '{8'h7e, 1'b0, 4'd3, 64'h7e7d_5e00_0000_0000},
    '{8'h7d, 1'b0, 4'd2, 64'h7d5d_0000_0000_0000},
    '{8'hff, 1'b0, 4'd1, 64'hff00_0000_0000_0000},
    '{8'h00, 1'b0, 4'd1, 64'h0000_0000_0000_0000},
    '{8'h55, 1'b1, 4'd0, 64'h0},
    '{8'hff, 1'b1, 4'd0, 64'h0},
    '{8'h7e, 1'b1, 4'd0, 64'h0},
    '{8'h7d, 1'b1, 4'd0, 64'h0},
    '{8'h01, 1'b0, 4'd2, 64'h7e01_0000_0000_0000},
    '{8'h80, 1'b0, 4'd1, 64'h8000_0000_0000_0000},
    '{8'h7f, 1'b0, 4'd1, 64'h7f00_0000_0000_0000},
    '{8'hfe, 1'b0, 4'd1, 64'hfe00_0000_0000_0000},
    '{8'h5e, 1'b0, 4'd1, 64'h5e00_0000_0000_0000},
    '{8'h5d, 1'b1, 4'd0, 64'h0},
    '{8'haa, 1'b1, 4'd0, 64'h0},
    '{8'h00, 1'b0, 4'd2, 64'h7e00_0000_0000_0000},
    '{8'h00, 1'b1, 4'd4, 64'h0000_007e_0000_0000},
    '{8'h7e, 1'b1, 4'd0, 64'h0},
    '{8'h20, 1'b1, 4'd0, 64'h0},
    '{8'h5e, 1'b1, 4'd0, 64'h0}
  };

  // msb-first crc-16 over one byte, one bit per pass
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    int i;
    r = c ^ {b, 8'h00};
    for (i = 0; i < 8; i++)
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  function automatic bit needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function void emit(input logic [7:0] b, input logic rl, input logic fe);
    line_t ln;
    ln.octet     = b;
    ln.run_last  = rl;
    ln.frame_end = fe;
    if (keep_pred)
      line_expect.push_back(ln);
  endfunction

  // rl lands on the final line byte of this octet
  function void emit_stuffed(input logic [7:0] b, input logic rl);
    if (needs_escape(b)) begin
      escapes_seen++;
      emit(ESC_BYTE, 1'b0, 1'b0);
      emit(b ^ ESC_XOR, rl, 1'b0);
    end else begin
      emit(b, rl, 1'b0);
    end
  endfunction

  function void encode_frame_byte(input logic [7:0] d, input logic l);
    if (!frame_open) begin
      emit(FLAG_BYTE, 1'b0, 1'b0);
      frame_open = 1'b1;
      line_crc   = 16'h0000;
    end
    line_crc = crc_step(line_crc, d);
    emit_stuffed(d, !l);
    if (l) begin
      emit_stuffed(line_crc[7:0], 1'b0);
      emit_stuffed(line_crc[15:8], 1'b0);
      emit(FLAG_BYTE, 1'b1, 1'b1);
      frame_open = 1'b0;
      line_crc   = 16'h0000;
      frames_sent++;
    end
    bytes_sent++;
  endfunction

  // closing byte that drives as many crc bytes as possible into the escape set
  function automatic logic [7:0] tail_for_stuffed_crc(input logic [15:0] c);
    logic [15:0] n;
    logic [7:0]  y;
    logic [7:0]  pick;
    int k;
    int start;
    int score;
    int top;
    start = $urandom_range(0, 255);
    pick  = start[7:0];
    top   = 0;
    for (k = 0; k < 256; k++) begin
      y = 8'(start + k);
      n = crc_step(c, y);
      score = int'(needs_escape(n[7:0])) + int'(needs_escape(n[15:8]));
      if (score > top) begin
        top  = score;
        pick = y;
      end
    end
    return pick;
  endfunction

  task automatic drive_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_in.valid     <= 1'b1;
    byte_in.data_byte <= d;
    byte_in.last_byte <= l;
    @(posedge clk);
    while (!byte_in.ready) @(posedge clk);
  endtask

  // line side: random back-pressure plus a long hold-off on each request
  initial begin : line_sink
    int gap;
    line_out.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        line_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        line_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      line_out.ready <= 1'b1;
      @(posedge clk);
      while (!line_out.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : line_check
    line_t want;
    if (!rst && line_out.valid && line_out.ready) begin
      if (line_expect.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected line byte %02h run_last %0d frame_end %0d",
                   line_out.out_byte, line_out.run_last, line_out.frame_end);
        mismatch_count++;
      end else begin
        want = line_expect.pop_front();
        checked_count++;
        if (line_out.out_byte !== want.octet || line_out.run_last !== want.run_last ||
            line_out.frame_end !== want.frame_end) begin
          if (mismatch_count < 10)
            $display("line byte %0d: expected %02h/%0d/%0d got %02h/%0d/%0d",
                     checked_count, want.octet, want.run_last, want.frame_end,
                     line_out.out_byte, line_out.run_last, line_out.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d line bytes outstanding", line_expect.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    row_t  row;
    line_t ln;
    logic [7:0] d;
    logic l;
    int r;
    int k;
    int flen;
    int sent;
    cycle_count    = 0;
    mismatch_count = 0;
    checked_count  = 0;
    frames_sent    = 0;
    bytes_sent     = 0;
    escapes_seen   = 0;
    holds_done     = 0;
    line_crc       = 16'h0000;
    frame_open     = 1'b0;
    keep_pred      = 1'b1;
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    hold_req       = 1'b0;
    clk            = 1'b0;
    rst            = 1'b1;
    byte_in.valid     = 1'b0;
    byte_in.data_byte = 8'h00;
    byte_in.last_byte = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_ROWS; r++) begin
      row = dir_rows[r];
      keep_pred = (row.nexp == 0);
      encode_frame_byte(row.data, row.last);
      keep_pred = 1'b1;
      for (k = 0; k < int'(row.nexp); k++) begin
        ln.octet     = row.exp[63 - 8*k -: 8];
        ln.run_last  = (k == int'(row.nexp) - 1);
        ln.frame_end = ln.run_last && row.last;
        line_expect.push_back(ln);
      end
      drive_byte(row.data, row.last);
    end

    // random frames, always closed so the run ends between frames
    sent = 0;
    hold_req = 1'b1;
    while (sent < RANDOM_BYTES) begin
      flen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
      for (k = 0; k < flen; k++) begin
        tx_burst = (sent >= 50 && sent < 80);
        rx_burst = (sent >= 60 && sent < 95);
        if (sent == 110)
          hold_req = 1'b1;
        l = (k == flen - 1);
        case ($urandom_range(0, 9))
          0, 1:    d = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
          2:       d = $urandom_range(0, 1) ? 8'hff : 8'h00;
          default: d = 8'($urandom_range(0, 255));
        endcase
        if (l && $urandom_range(0, 2) == 0)
          d = tail_for_stuffed_crc(frame_open ? line_crc : 16'h0000);
        encode_frame_byte(d, l);
        drive_byte(d, l);
        sent++;
      end
    end
    byte_in.valid <= 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;

    while (line_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("framed %0d input bytes into %0d frames, %0d line bytes checked",
             bytes_sent, frames_sent, checked_count);
    $display("%0d stuffed octets, %0d long line hold-offs, %0d mismatches",
             escapes_seen, holds_done, mismatch_count);
    if (mismatch_count == 0 && line_expect.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== byte_stuffing_framer_crc16.f =====
sv/bsf_pkg.sv
sv/bsf_in_if.sv
sv/bsf_out_if.sv
sv/bsf_front.sv
sv/bsf_queue.sv
sv/bsf_back.sv
sv/byte_stuffing_framer_crc16.sv
tb/sv/byte_stuffing_framer_crc16_tb.sv
